// ----- hdl/assert_macros.svh -----
// Assertion macros shared by the encoder RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off while reset is asserted.
`define CRE_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, held off while reset is asserted.
`define CRE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hdl/cre_pkg.sv -----
// Types and constants of the carryless range encoder.
package cre_pkg;

	localparam int RANGE_W = 64;
	localparam int CUM_W   = 24;
	localparam int FREQ_W  = 25;
	localparam int BYTE_W  = 8;
	localparam int CNT_W   = 6;
	localparam int EMIT_W  = 5;

	localparam logic             CMD_ENCODE = 1'b0;
	localparam logic             CMD_FLUSH  = 1'b1;

	localparam logic [CNT_W-1:0]  DIV_LAST   = CNT_W'(RANGE_W - 1);
	localparam logic [CNT_W-1:0]  CUM_LAST   = CNT_W'(CUM_W - 1);
	localparam logic [CNT_W-1:0]  FREQ_LAST  = CNT_W'(FREQ_W - 1);
	localparam logic [CNT_W-1:0]  FLUSH_LAST = CNT_W'(RANGE_W / BYTE_W - 1);
	localparam logic [EMIT_W-1:0] MAX_EMIT   = EMIT_W'(16);

	// Bottom bound 2^48 less one: mask of the low 48 bits.
	localparam logic [RANGE_W-1:0] BOT_MASK = 64'h0000_FFFF_FFFF_FFFF;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_MUL1,
		ST_MUL2,
		ST_TEST,
		ST_CUT,
		ST_SHIFT,
		ST_FLUSH
	} cre_state_t;

endpackage

// ----- hdl/cre_in_if.sv -----
// Input channel: one encode or flush command per transfer.
interface cre_in_if import cre_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              command;
	logic [CUM_W-1:0]  cum_count;
	logic [FREQ_W-1:0] sym_freq;
	logic [FREQ_W-1:0] total;

	modport source(output valid, command, cum_count, sym_freq, total, input ready);
	modport sink(input valid, command, cum_count, sym_freq, total, output ready);
endinterface

// ----- hdl/cre_out_if.sv -----
// Output channel: one compressed byte per transfer.
interface cre_out_if import cre_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] out_byte;
	logic              last;

	modport source(output valid, out_byte, last, input ready);
	modport sink(input valid, out_byte, last, output ready);
endinterface

// ----- hdl/carryless_range_encoder.sv -----
// 64-bit carryless range encoder with a shared 64-bit adder under a sequencer.
//
//  channel  | dir | payload                                  | handshake
//  in_ch    | in  | command, cum_count, sym_freq, total      | valid/ready
//  out_ch   | out | out_byte, last                           | valid/ready
//
// Encode: 64 division steps and 24 + 25 multiply steps, then per byte an interval
// test, a range cut where needed and the shift; in_ch.ready returns when a test
// finds no byte to emit or the byte cap is hit. Flush: the 8 bytes of low.
// Division and multiply steps go one bit per cycle through the single 64-bit adder.
// Reset clears low to zero and range to all ones. in_ch.ready is high only when
// no item is in work; a stalled out_ch holds the sequencer at the byte it emits.
`include "assert_macros.svh"

module carryless_range_encoder import cre_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	cre_in_if.sink   in_ch,
	cre_out_if.source out_ch
);

	localparam int TOP = RANGE_W - 1;

	cre_state_t state_q, state_d;

	logic [RANGE_W-1:0] low_q;
	logic [RANGE_W-1:0] range_q;
	logic [RANGE_W-1:0] m_q;
	logic [FREQ_W-1:0]  mb_q;
	logic [FREQ_W-1:0]  freq_q;
	logic [FREQ_W-1:0]  tot_q;
	logic [FREQ_W-1:0]  rem_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [EMIT_W-1:0]  n_q;
	logic               pend_q;
	logic [BYTE_W-1:0]  pend_byte_q;
	logic               out_valid_q;
	logic [BYTE_W-1:0]  out_byte_q;
	logic               out_last_q;

	logic [RANGE_W-1:0] alu_a, alu_b;
	logic               alu_sub;
	logic [RANGE_W:0]   sum;
	logic [FREQ_W:0]    rem_sh;
	logic               ge;
	logic [RANGE_W-1:0] q_next;
	logic               near, below, go;
	logic               out_free;
	logic               ld_out;
	logic [BYTE_W-1:0]  ob_d;
	logic               last_d;

	assign rem_sh   = {rem_q, range_q[TOP]};
	assign ge       = sum[RANGE_W];
	assign q_next   = {range_q[TOP-1:0], ge};
	assign out_free = !out_valid_q || out_ch.ready;

	// Shared adder: divide step, multiply step, interval test and negation.
	always_comb begin
		alu_a   = '0;
		alu_b   = '0;
		alu_sub = 1'b0;
		case (state_q)
			ST_DIV: begin
				alu_a   = RANGE_W'(rem_sh);
				alu_b   = RANGE_W'(tot_q);
				alu_sub = 1'b1;
			end
			ST_MUL1: begin
				alu_a = low_q;
				alu_b = m_q;
			end
			ST_MUL2: begin
				alu_a = range_q;
				alu_b = m_q;
			end
			ST_TEST: begin
				alu_a = low_q;
				alu_b = range_q;
			end
			ST_CUT: begin
				alu_b   = low_q;
				alu_sub = 1'b1;
			end
			default: begin
				alu_a = '0;
			end
		endcase
	end

	assign sum = {1'b0, alu_a} + {1'b0, alu_b ^ {RANGE_W{alu_sub}}}
		+ (RANGE_W + 1)'(alu_sub);

	assign near  = (low_q[TOP -: BYTE_W] ^ sum[TOP -: BYTE_W]) == '0;
	assign below = range_q[TOP:48] == '0;
	assign go    = near || below;

	always_comb begin
		state_d = state_q;
		ld_out  = 1'b0;
		ob_d    = pend_byte_q;
		last_d  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (in_ch.valid) begin
					if (in_ch.command == CMD_FLUSH) state_d = ST_FLUSH;
					else if (in_ch.total != '0) state_d = ST_DIV;
				end
			end
			ST_DIV: begin
				if (cnt_q == DIV_LAST) state_d = ST_MUL1;
			end
			ST_MUL1: begin
				if (cnt_q == CUM_LAST) state_d = ST_MUL2;
			end
			ST_MUL2: begin
				if (cnt_q == FREQ_LAST) state_d = ST_TEST;
			end
			ST_TEST: begin
				if (pend_q) begin
					// A held byte is last when nothing follows it.
					if (out_free) begin
						ld_out = 1'b1;
						if (n_q == MAX_EMIT || !go) begin
							last_d  = 1'b1;
							state_d = ST_IDLE;
						end
					end
				end else if (!go) begin
					state_d = ST_IDLE;
				end else if (near) begin
					state_d = ST_SHIFT;
				end else begin
					state_d = ST_CUT;
				end
			end
			ST_CUT: begin
				state_d = ST_SHIFT;
			end
			ST_SHIFT: begin
				state_d = ST_TEST;
			end
			ST_FLUSH: begin
				ob_d   = low_q[TOP -: BYTE_W];
				last_d = cnt_q == FLUSH_LAST;
				if (out_free) begin
					ld_out = 1'b1;
					if (last_d) state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_q       <= '0;
			range_q     <= '1;
			cnt_q       <= '0;
			n_q         <= '0;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (ld_out) out_valid_q <= 1'b1;
			else if (out_ch.ready) out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					cnt_q  <= '0;
					n_q    <= '0;
					pend_q <= 1'b0;
				end
				ST_DIV: begin
					range_q <= q_next;
					cnt_q   <= (cnt_q == DIV_LAST) ? '0 : cnt_q + 1'b1;
				end
				ST_MUL1: begin
					if (mb_q[0]) low_q <= sum[TOP:0];
					if (cnt_q == CUM_LAST) begin
						cnt_q   <= '0;
						range_q <= '0;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_MUL2: begin
					if (mb_q[0]) range_q <= sum[TOP:0];
					cnt_q <= (cnt_q == FREQ_LAST) ? '0 : cnt_q + 1'b1;
				end
				ST_TEST: begin
					if (ld_out) pend_q <= 1'b0;
				end
				ST_CUT: begin
					range_q <= sum[TOP:0] & BOT_MASK;
				end
				ST_SHIFT: begin
					low_q   <= low_q << BYTE_W;
					range_q <= range_q << BYTE_W;
					n_q     <= n_q + 1'b1;
					pend_q  <= 1'b1;
				end
				ST_FLUSH: begin
					if (ld_out) begin
						low_q <= low_q << BYTE_W;
						if (last_d) begin
							cnt_q   <= '0;
							range_q <= '1;
						end else begin
							cnt_q <= cnt_q + 1'b1;
						end
					end
				end
				default: begin
					cnt_q <= '0;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (ld_out) begin
			out_byte_q <= ob_d;
			out_last_q <= last_d;
		end
		case (state_q)
			ST_IDLE: begin
				rem_q  <= '0;
				mb_q   <= FREQ_W'(in_ch.cum_count);
				freq_q <= in_ch.sym_freq;
				tot_q  <= in_ch.total;
			end
			ST_DIV: begin
				rem_q <= ge ? sum[FREQ_W-1:0] : rem_sh[FREQ_W-1:0];
				if (cnt_q == DIV_LAST) m_q <= q_next;
			end
			ST_MUL1: begin
				if (cnt_q == CUM_LAST) begin
					m_q  <= range_q;
					mb_q <= freq_q;
				end else begin
					m_q  <= m_q << 1;
					mb_q <= mb_q >> 1;
				end
			end
			ST_MUL2: begin
				m_q  <= m_q << 1;
				mb_q <= mb_q >> 1;
			end
			ST_SHIFT: begin
				pend_byte_q <= low_q[TOP -: BYTE_W];
			end
			default: begin
				pend_byte_q <= pend_byte_q;
			end
		endcase
	end

	assign in_ch.ready     = state_q == ST_IDLE;
	assign out_ch.valid    = out_valid_q;
	assign out_ch.out_byte = out_byte_q;
	assign out_ch.last     = out_last_q;

	`CRE_ASSERT_IMPL(a_rem_below_total, clk, arst_n, state_q == ST_DIV, rem_q < tot_q,
		"division remainder reached the total")
	`CRE_ASSERT_IMPL(a_pend_in_test, clk, arst_n, pend_q, state_q == ST_TEST,
		"held byte outside the test step")
	`CRE_ASSERT_IMPL(a_shift_cap, clk, arst_n, state_q == ST_SHIFT, n_q < MAX_EMIT,
		"renormalisation ran past the byte cap")
	`CRE_ASSERT_NEXT(a_flush_clears, clk, arst_n, state_q == ST_FLUSH && ld_out && last_d,
		low_q == '0 && range_q == '1, "flush left the interval dirty")

endmodule

// ----- tb/tb_carryless_range_encoder.sv -----
// Self-checking testbench of the carryless range encoder: streamed encode and flush commands.
module tb_carryless_range_encoder import cre_pkg::*;;

	localparam logic [RANGE_W-1:0] TOP_BOUND  = 64'h0100_0000_0000_0000;
	localparam logic [RANGE_W-1:0] BOT_BOUND  = 64'h0001_0000_0000_0000;
	localparam int                 FULL_TOTAL = 1 << 24;
	localparam int                 QUIET      = 16;
	localparam int                 RAND_ITEMS = 180;

	typedef struct {
		logic              command;
		logic [CUM_W-1:0]  cum_count;
		logic [FREQ_W-1:0] sym_freq;
		logic [FREQ_W-1:0] total;
		bit                drain_first;
	} enc_item_t;

	typedef struct {
		logic [BYTE_W-1:0] out_byte;
		logic              last;
	} enc_byte_t;

	logic clk;
	logic arst_n;

	cre_in_if  in_ch();
	cre_out_if out_ch();

	carryless_range_encoder dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	enc_item_t pending_items[$];
	enc_byte_t expected_stream[$];
	enc_item_t cur_item;
	enc_byte_t want;

	logic [RANGE_W-1:0] enc_low;
	logic [RANGE_W-1:0] enc_range;

	int item_total;
	int sent_count;
	int fail_count;
	int burst_left;
	int gap_left;
	int quiet_cycles;
	int stall_cycle;
	int stall_mode;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	initial begin
		#1_500_000;
		$display("simulation failed");
		$finish;
	end

	// Narrow the interval or dump low, and queue the bytes that must come out.
	task automatic predict_bytes(input enc_item_t it);
		logic [BYTE_W-1:0] emitted[$];
		enc_byte_t         b;
		logic              go;
		int                n;
		emitted = {};
		if (it.command == CMD_FLUSH) begin
			for (n = 0; n < 8; n++) begin
				emitted = {emitted, enc_low[63:56]};
				enc_low = enc_low << 8;
			end
			enc_low = '0;
			enc_range = '1;
		end else if (it.total != '0) begin
			enc_range = enc_range / {39'd0, it.total};
			enc_low = enc_low + {40'd0, it.cum_count} * enc_range;
			enc_range = enc_range * {39'd0, it.sym_freq};
			go = 1'b1;
			n = 0;
			while (go && n < int'(MAX_EMIT)) begin
				if ((enc_low ^ (enc_low + enc_range)) < TOP_BOUND) begin
					go = 1'b1;
				end else if (enc_range < BOT_BOUND) begin
					// cut range so the interval stops at the next 2^48 boundary
					enc_range = (~enc_low + 64'd1) & BOT_MASK;
					go = 1'b1;
				end else begin
					go = 1'b0;
				end
				if (go) begin
					emitted = {emitted, enc_low[63:56]};
					enc_low = enc_low << 8;
					enc_range = enc_range << 8;
					n++;
				end
			end
		end
		for (n = 0; n < emitted.size(); n++) begin
			b.out_byte = emitted[n];
			b.last = (n == emitted.size() - 1);
			expected_stream = {expected_stream, b};
		end
	endtask

	function automatic enc_item_t mk_item(logic cmd, int unsigned cum, int unsigned freq,
			int unsigned tot, bit drain);
		enc_item_t it;
		it.command = cmd;
		it.cum_count = CUM_W'(cum);
		it.sym_freq = FREQ_W'(freq);
		it.total = FREQ_W'(tot);
		it.drain_first = drain;
		return it;
	endfunction

	function automatic enc_item_t mk_symbol();
		int unsigned tot;
		int unsigned cum;
		int unsigned freq;
		case ($urandom_range(0, 3))
			0: tot = $urandom_range(2, 256);
			1: tot = $urandom_range(257, 65536);
			2: tot = FULL_TOTAL;
			default: tot = $urandom_range(1, FULL_TOTAL);
		endcase
		cum = $urandom_range(0, tot - 1);
		// skew towards narrow symbols so that many bytes come out
		if ($urandom_range(0, 1) == 0 && tot - cum > 16)
			freq = $urandom_range(1, 16);
		else
			freq = $urandom_range(1, tot - cum);
		return mk_item(CMD_ENCODE, cum, freq, tot, 1'b0);
	endfunction

	function automatic enc_item_t mk_noise();
		logic        cmd;
		int unsigned tot;
		cmd = ($urandom_range(0, 7) == 0) ? CMD_FLUSH : CMD_ENCODE;
		tot = ($urandom_range(0, 5) == 0) ? 0 : $urandom;
		return mk_item(cmd, $urandom, $urandom, tot, 1'b0);
	endfunction

	// Stimulus and end of run.
	initial begin
		enc_item_t it;
		int        counted;
		int        len;
		int        k;
		bit        drain_done;

		pending_items = {pending_items, mk_item(CMD_FLUSH, 0, 0, 0, 1'b0)};
		pending_items = {pending_items, mk_item(CMD_ENCODE, 0, 1, 1, 1'b0)};
		pending_items = {pending_items,
			mk_item(CMD_ENCODE, 24'hFF_FFFF, 25'h1FF_FFFF, 0, 1'b0)};
		pending_items = {pending_items,
			mk_item(CMD_ENCODE, 24'hFF_FFFF, 1, FULL_TOTAL, 1'b0)};
		pending_items = {pending_items,
			mk_item(CMD_ENCODE, 0, FULL_TOTAL, FULL_TOTAL, 1'b0)};
		pending_items = {pending_items, mk_item(CMD_ENCODE, 0, 1, FULL_TOTAL, 1'b0)};
		pending_items = {pending_items, mk_item(CMD_ENCODE, 1, 1, 3, 1'b0)};
		pending_items = {pending_items, mk_item(CMD_FLUSH, 0, 0, 0, 1'b0)};
		// zero frequency collapses range: emission cap applies
		pending_items = {pending_items, mk_item(CMD_ENCODE, 5, 0, 7, 1'b0)};
		pending_items = {pending_items, mk_item(CMD_ENCODE, 1, 1, 2, 1'b0)};
		pending_items = {pending_items,
			mk_item(CMD_FLUSH, 24'hFF_FFFF, 25'h1FF_FFFF, 25'h1FF_FFFF, 1'b1)};
		pending_items = {pending_items,
			mk_item(CMD_ENCODE, 24'hFF_FFFF, 25'h1FF_FFFF, 25'h1FF_FFFF, 1'b0)};
		pending_items = {pending_items,
			mk_item(CMD_ENCODE, 24'hFF_FFFF, 25'h1FF_FFFF, 5, 1'b0)};
		pending_items = {pending_items, mk_item(CMD_FLUSH, 0, 0, 0, 1'b0)};
		pending_items = {pending_items, mk_item(CMD_ENCODE, 0, 0, 0, 1'b0)};
		pending_items = {pending_items,
			mk_item(CMD_ENCODE, 24'hAA_AAAA, 25'h155_5555, 25'h0AA_AAAB, 1'b0)};
		pending_items = {pending_items,
			mk_item(CMD_ENCODE, 24'h55_5555, 25'h0AA_AAAA, FULL_TOTAL, 1'b0)};
		pending_items = {pending_items, mk_item(CMD_FLUSH, 0, 0, 0, 1'b0)};

		counted = 0;
		drain_done = 0;
		while (counted < RAND_ITEMS) begin
			if ($urandom_range(0, 99) < 85) begin
				len = $urandom_range(1, 12);
				for (k = 0; k < len; k++) begin
					pending_items = {pending_items, mk_symbol()};
					counted++;
				end
				it = mk_item(CMD_FLUSH, $urandom, $urandom, $urandom, 1'b0);
			end else begin
				it = mk_noise();
			end
			if (!drain_done && counted >= RAND_ITEMS / 2) begin
				it.drain_first = 1'b1;
				drain_done = 1;
			end
			pending_items = {pending_items, it};
			if (it.command == CMD_FLUSH || it.total != '0)
				counted++;
		end
		item_total = pending_items.size();

		@(posedge arst_n);
		while (sent_count != item_total || expected_stream.size() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
		if (fail_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	// Sender: bursts of commands with random gaps; valid holds until the transfer.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
			in_ch.command <= CMD_ENCODE;
			in_ch.cum_count <= '0;
			in_ch.sym_freq <= '0;
			in_ch.total <= '0;
			enc_low = '0;
			enc_range = '1;
			sent_count = 0;
			burst_left = 1;
			gap_left = 0;
			quiet_cycles = 0;
		end else begin
			if (in_ch.valid && in_ch.ready) begin
				predict_bytes(cur_item);
				sent_count++;
			end
			if (expected_stream.size() == 0 && in_ch.ready && !in_ch.valid)
				quiet_cycles++;
			else
				quiet_cycles = 0;
			if (!in_ch.valid || in_ch.ready) begin
				if (gap_left > 0) begin
					gap_left--;
					in_ch.valid <= 1'b0;
				end else if (pending_items.size() == 0 ||
						(pending_items[0].drain_first && quiet_cycles < QUIET)) begin
					in_ch.valid <= 1'b0;
				end else begin
					cur_item = pending_items.pop_front();
					in_ch.valid <= 1'b1;
					in_ch.command <= cur_item.command;
					in_ch.cum_count <= cur_item.cum_count;
					in_ch.sym_freq <= cur_item.sym_freq;
					in_ch.total <= cur_item.total;
					burst_left--;
					if (burst_left <= 0) begin
						burst_left = $urandom_range(1, 24);
						gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 180);
					end
				end
			end
		end
	end

	// Receiver: stall pattern switches between randomly drawn modes.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
			fail_count = 0;
			stall_cycle = 0;
			stall_mode = 0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				if (expected_stream.size() == 0) begin
					$error("out_byte: no byte expected, actual %02h", out_ch.out_byte);
					fail_count++;
				end else begin
					want = expected_stream.pop_front();
					if (out_ch.out_byte !== want.out_byte) begin
						$error("out_byte: expected %02h, actual %02h", want.out_byte,
							out_ch.out_byte);
						fail_count++;
					end
					if (out_ch.last !== want.last) begin
						$error("last: expected %0b, actual %0b", want.last, out_ch.last);
						fail_count++;
					end
				end
			end
			stall_cycle++;
			if (stall_cycle % 150 == 0)
				stall_mode = $urandom_range(0, 3);
			case (stall_mode)
				0: out_ch.ready <= 1'b1;
				1: out_ch.ready <= stall_cycle[0];
				2: out_ch.ready <= ($urandom_range(0, 3) != 0);
				default: out_ch.ready <= (stall_cycle % 16 >= 9);
			endcase
		end
	end

endmodule
